// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, masked while reset is asserted.
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ----- rtl/lgs_pkg.sv -----
// Types and constants for the life grid stepper.
package lgs_pkg;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_READ  = 2'd3
    } lgs_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_LOAD
    } lgs_state_t;

    typedef struct packed {
        lgs_cmd_t cmd;
        logic     target;
        logic     interior;
    } lgs_ctrl_t;

    localparam logic [3:0] SURVIVE_LO = 4'd2;
    localparam logic [3:0] BIRTH_CNT  = 4'd3;

    localparam int unsigned ADDR_EXT_W = 9;

endpackage

// ----- rtl/lgs_row_cell.sv -----
// One row of the grid: a cell of the row chain, shifting toward row zero.
module lgs_row_cell #(
    parameter int unsigned WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] row_bits_reg;
    logic [WIDTH-1:0] row_bits_next;

    always_comb
    begin
        row_bits_next = shift ? din : row_bits_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bits_reg <= '0;
        end
        else
        begin
            row_bits_reg <= row_bits_next;
        end
    end

    assign dout = row_bits_reg;

endmodule

// ----- rtl/lgs_row_engine.sv -----
// Next value of the head row of the chain: life rule, single-cell edit or kept as is.
module lgs_row_engine #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned IDXW  = 6
) (
    input  lgs_pkg::lgs_ctrl_t ctrl,
    input  logic [IDXW-1:0]    col_idx,
    input  logic               col_ok,
    input  logic [WIDTH-1:0]   above,
    input  logic [WIDTH-1:0]   cur,
    input  logic [WIDTH-1:0]   below,
    output logic [WIDTH-1:0]   new_row
);

    logic [WIDTH-1:0] life_row;
    logic [WIDTH-1:0] edit_row;

    always_comb
    begin
        logic [3:0] cnt;
        life_row = '0;
        for (int c = 1; c < int'(WIDTH) - 1; c++)
        begin
            cnt = 4'(above[c-1]) + 4'(above[c]) + 4'(above[c+1])
                + 4'(cur[c-1])                  + 4'(cur[c+1])
                + 4'(below[c-1]) + 4'(below[c]) + 4'(below[c+1]);
            if (cur[c])
            begin
                life_row[c] = (cnt == lgs_pkg::SURVIVE_LO) || (cnt == lgs_pkg::BIRTH_CNT);
            end
            else
            begin
                life_row[c] = (cnt == lgs_pkg::BIRTH_CNT);
            end
        end
        if (!ctrl.interior)
        begin
            life_row = '0;
        end
    end

    always_comb
    begin
        edit_row = cur;
        if (ctrl.target && col_ok)
        begin
            if (ctrl.cmd == lgs_pkg::CMD_SET)
            begin
                edit_row[col_idx] = 1'b1;
            end
            else if (ctrl.cmd == lgs_pkg::CMD_CLEAR)
            begin
                edit_row[col_idx] = 1'b0;
            end
        end
    end

    always_comb
    begin
        case (ctrl.cmd)
            lgs_pkg::CMD_STEP: new_row = life_row;
            lgs_pkg::CMD_SET,
            lgs_pkg::CMD_CLEAR: new_row = edit_row;
            default:            new_row = cur;
        endcase
    end

endmodule

// ----- rtl/life_grid_stepper_top.sv -----
// Top level of the life grid stepper: row chain, head engine and command sequencer.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------
//  in      | in_valid / in_stall   | command, col, row
//  out     | out_valid / out_stall | cell_alive
//
// Every command rotates the whole grid once through the row chain, one row per cycle.
// From accept to the next accept, a command runs the rotation through the head engine,
// a hand-off to the output register and an idle state in which the next beat is taken.
// Reset clears every grid cell at once; no clearing pass.
// in_stall is high from accept until the hand-off; a result waiting under out_stall
// holds the hand-off, the next beat is still taken once the result sits in the output.
`include "assert_macros.svh"

module life_grid_stepper_top #(
    parameter int unsigned GRID_SIZE = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [5:0] col,
    input  logic [5:0] row,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       cell_alive
);

    localparam int unsigned IDXW = $clog2(GRID_SIZE);
    localparam int unsigned EXTW = lgs_pkg::ADDR_EXT_W;
    localparam logic [IDXW-1:0] LAST = IDXW'(GRID_SIZE - 1);

    lgs_pkg::lgs_state_t state_reg, state_next;
    logic [IDXW-1:0]     t_reg, t_next;
    lgs_pkg::lgs_cmd_t   cmd_reg, cmd_next;
    logic [IDXW-1:0]     tgt_row_reg, tgt_row_next;
    logic [IDXW-1:0]     tgt_col_reg, tgt_col_next;
    logic                on_grid_reg, on_grid_next;
    logic                hit_reg, hit_next;
    logic [GRID_SIZE-1:0] prev_reg, prev_next;
    logic                out_valid_reg, out_valid_next;
    logic                cell_alive_reg, cell_alive_next;

    logic [GRID_SIZE-1:0] rows [GRID_SIZE];
    logic [GRID_SIZE-1:0] new_row;
    lgs_pkg::lgs_ctrl_t   ctrl;
    logic                 accept;
    logic                 shift;
    logic                 load_out;
    logic [EXTW-1:0]      row_ext;
    logic [EXTW-1:0]      col_ext;
    logic                 in_on_grid;

    assign accept     = in_valid && !in_stall;
    assign row_ext    = EXTW'(row);
    assign col_ext    = EXTW'(col);
    assign in_on_grid = (row_ext < EXTW'(GRID_SIZE)) && (col_ext < EXTW'(GRID_SIZE));

    genvar k;
    generate
        for (k = 0; k < GRID_SIZE; k++)
        begin : g_chain
            lgs_row_cell #(
                .WIDTH(GRID_SIZE)
            ) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .shift(shift),
                .din  ((k == GRID_SIZE - 1) ? new_row : rows[(k + 1) % GRID_SIZE]),
                .dout (rows[k])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl.cmd      = cmd_reg;
        ctrl.target   = on_grid_reg && (t_reg == tgt_row_reg);
        ctrl.interior = (t_reg != '0) && (t_reg != LAST);
    end

    lgs_row_engine #(
        .WIDTH(GRID_SIZE),
        .IDXW (IDXW)
    ) u_engine (
        .ctrl   (ctrl),
        .col_idx(tgt_col_reg),
        .col_ok (on_grid_reg),
        .above  (prev_reg),
        .cur    (rows[0]),
        .below  (rows[1]),
        .new_row(new_row)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lgs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lgs_pkg::ST_RUN;
                end
            end
            lgs_pkg::ST_RUN:
            begin
                if (t_reg == LAST)
                begin
                    state_next = lgs_pkg::ST_LOAD;
                end
            end
            lgs_pkg::ST_LOAD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = lgs_pkg::ST_IDLE;
                end
            end
            default: state_next = lgs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        shift    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            lgs_pkg::ST_IDLE: in_stall = 1'b0;
            lgs_pkg::ST_RUN:  shift    = 1'b1;
            lgs_pkg::ST_LOAD: load_out = !out_valid_reg || !out_stall;
            default:          in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        t_next          = t_reg;
        cmd_next        = cmd_reg;
        tgt_row_next    = tgt_row_reg;
        tgt_col_next    = tgt_col_reg;
        on_grid_next    = on_grid_reg;
        hit_next        = hit_reg;
        prev_next       = prev_reg;
        out_valid_next  = out_valid_reg;
        cell_alive_next = cell_alive_reg;
        if (accept)
        begin
            t_next       = '0;
            cmd_next     = lgs_pkg::lgs_cmd_t'(command);
            tgt_row_next = IDXW'(row_ext);
            tgt_col_next = IDXW'(col_ext);
            on_grid_next = in_on_grid;
            hit_next     = 1'b0;
        end
        if (shift)
        begin
            t_next    = t_reg + IDXW'(1);
            prev_next = rows[0];
            if (ctrl.target)
            begin
                hit_next = new_row[tgt_col_reg];
            end
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            cell_alive_next = hit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lgs_pkg::ST_IDLE;
            t_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        tgt_row_reg    <= tgt_row_next;
        tgt_col_reg    <= tgt_col_next;
        on_grid_reg    <= on_grid_next;
        hit_reg        <= hit_next;
        prev_reg       <= prev_next;
        cell_alive_reg <= cell_alive_next;
    end

    assign out_valid  = out_valid_reg;
    assign cell_alive = cell_alive_reg;

    `ASSERT_CLK(a_accept_starts_sweep, accept |=> (state_reg == lgs_pkg::ST_RUN && t_reg == '0), "accepted beat did not start a sweep")
    `ASSERT_CLK(a_sweep_ends, (state_reg == lgs_pkg::ST_RUN && t_reg == LAST) |=> (state_reg == lgs_pkg::ST_LOAD), "sweep did not end after a full rotation")
    `ASSERT_CLK(a_result_from_load, $rose(out_valid_reg) |-> ($past(state_reg) == lgs_pkg::ST_LOAD), "result raised outside hand-off")
    `ASSERT_IMPLY(a_offgrid_dead, (state_reg == lgs_pkg::ST_LOAD && !on_grid_reg), !hit_reg, "off-grid command returned a live cell")

endmodule

// ----- dv/lgs_life_sb_pkg.sv -----
// Life grid scoreboard: cell grid predictor and expected cell value queue.
`timescale 1ns / 1ps

package lgs_life_sb_pkg;

    localparam int GRID = 64;

    class life_scoreboard;

        bit cells [GRID*GRID];
        bit expected_alive_q [$];
        int errors;

        function new();
            cells = '{default: 1'b0};
            errors = 0;
        endfunction

        function int pending();
            return expected_alive_q.size();
        endfunction

        // Apply one accepted command to the grid and queue the addressed cell's value.
        function void note_command(lgs_pkg::lgs_cmd_t cmd, bit [5:0] c, bit [5:0] r);
            bit nxt [GRID*GRID];
            bit on_grid;
            int idx;
            int n;
            on_grid = (c < GRID) && (r < GRID);
            idx = on_grid ? int'(r) * GRID + int'(c) : 0;
            case (cmd)
                lgs_pkg::CMD_STEP:
                begin
                    nxt = '{default: 1'b0};
                    for (int y = 1; y < GRID - 1; y++)
                    begin
                        for (int x = 1; x < GRID - 1; x++)
                        begin
                            n = 0;
                            for (int dy = -1; dy <= 1; dy++)
                                for (int dx = -1; dx <= 1; dx++)
                                    if (dy != 0 || dx != 0)
                                        n += cells[(y + dy) * GRID + x + dx];
                            if (cells[y * GRID + x])
                                nxt[y * GRID + x] = (n == lgs_pkg::SURVIVE_LO)
                                                 || (n == lgs_pkg::BIRTH_CNT);
                            else
                                nxt[y * GRID + x] = (n == lgs_pkg::BIRTH_CNT);
                        end
                    end
                    cells = nxt;
                end
                lgs_pkg::CMD_SET:
                begin
                    if (on_grid)
                        cells[idx] = 1'b1;
                end
                lgs_pkg::CMD_CLEAR:
                begin
                    if (on_grid)
                        cells[idx] = 1'b0;
                end
                default:
                begin
                end
            endcase
            expected_alive_q.push_back(on_grid ? cells[idx] : 1'b0);
        endfunction

        function void check_result(bit got);
            bit want;
            if (expected_alive_q.size() == 0)
            begin
                errors++;
                $display("%0t ERROR unexpected beat: expected none, actual cell_alive %0b",
                         $time, got);
                return;
            end
            want = expected_alive_q.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t ERROR cell_alive: expected %0b, actual %0b", $time, want, got);
            end
        endfunction

    endclass

endpackage

// ----- dv/tb_life_grid_stepper_top.sv -----
// Testbench for life_grid_stepper_top: directed and random grid commands, predicted cell values.
`timescale 1ns / 1ps

module tb_life_grid_stepper_top;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = lgs_life_sb_pkg::GRID + 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] command = lgs_pkg::CMD_READ;
    logic [5:0] col = '0;
    logic [5:0] row = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       cell_alive;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int beats_sent = 0;
    int cycles = 0;

    lgs_life_sb_pkg::life_scoreboard sb = new();

    life_grid_stepper_top #(.GRID_SIZE(lgs_life_sb_pkg::GRID)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .col        (col),
        .row        (row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_alive (cell_alive)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** life_grid_stepper_top: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(cell_alive);
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic send(lgs_pkg::lgs_cmd_t cmd, int c, int r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        col <= c[5:0];
        row <= r[5:0];
        do
            @(posedge clk);
        while (in_stall);
        sb.note_command(cmd, c[5:0], r[5:0]);
        beats_sent++;
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    // Random seed patterns in a small window, evolved and probed; some noise anywhere.
    task automatic run_phase(int tx_pct, int rx_pct, int target);
        int c0;
        int r0;
        int k;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        while (beats_sent < target)
        begin
            if ($urandom_range(9) == 0)
            begin
                send(lgs_pkg::lgs_cmd_t'($urandom_range(3)), $urandom_range(63),
                     $urandom_range(63));
            end
            else
            begin
                c0 = $urandom_range(56);
                r0 = $urandom_range(56);
                k = $urandom_range(3, 12);
                repeat (k)
                    send(lgs_pkg::lgs_cmd_t'($urandom_range(5) == 0 ? lgs_pkg::CMD_CLEAR
                                                                     : lgs_pkg::CMD_SET),
                         c0 + $urandom_range(7), r0 + $urandom_range(7));
                k = $urandom_range(1, 6);
                repeat (k)
                    send(lgs_pkg::CMD_STEP, c0 + $urandom_range(7), r0 + $urandom_range(7));
                k = $urandom_range(1, 3);
                repeat (k)
                    send(lgs_pkg::CMD_READ, c0 + $urandom_range(7), r0 + $urandom_range(7));
            end
        end
        wait_all_results();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners, clear of a dead cell
        send(lgs_pkg::CMD_READ, 0, 0);
        send(lgs_pkg::CMD_SET, 0, 0);
        send(lgs_pkg::CMD_SET, 63, 63);
        send(lgs_pkg::CMD_READ, 63, 63);
        send(lgs_pkg::CMD_CLEAR, 0, 0);
        send(lgs_pkg::CMD_READ, 0, 0);
        send(lgs_pkg::CMD_CLEAR, 5, 5);
        send(lgs_pkg::CMD_SET, 63, 0);
        send(lgs_pkg::CMD_SET, 0, 63);
        // blinker, one cell set twice
        send(lgs_pkg::CMD_SET, 10, 10);
        send(lgs_pkg::CMD_SET, 11, 10);
        send(lgs_pkg::CMD_SET, 12, 10);
        send(lgs_pkg::CMD_SET, 12, 10);
        send(lgs_pkg::CMD_STEP, 11, 9);
        send(lgs_pkg::CMD_READ, 10, 10);
        send(lgs_pkg::CMD_STEP, 11, 10);
        // live border cells feed a birth inside, border itself dies
        send(lgs_pkg::CMD_SET, 5, 0);
        send(lgs_pkg::CMD_SET, 6, 0);
        send(lgs_pkg::CMD_SET, 7, 0);
        send(lgs_pkg::CMD_SET, 63, 30);
        send(lgs_pkg::CMD_SET, 63, 31);
        send(lgs_pkg::CMD_SET, 63, 32);
        send(lgs_pkg::CMD_STEP, 6, 0);
        send(lgs_pkg::CMD_READ, 6, 1);
        send(lgs_pkg::CMD_STEP, 62, 31);
        wait_all_results();

        run_phase(0, 0, 175);
        run_phase(47, 0, 325);
        run_phase(0, 47, 475);
        run_phase(30, 30, 625);

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("** life_grid_stepper_top: PASSED **");
        else
            $display("** life_grid_stepper_top: FAILED **");
        $finish;
    end

endmodule
